FILE: rtl/tws_pkg.sv
// ----------------------------------------------------------------------------
// tws_pkg: shared types and constants
// Command codes, step phases and the pin-step record passed between the step
// decoder and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package tws_pkg;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_STOP  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	// Step phase inside one bit (or inside a start / stop / ack pair).
	localparam logic [1:0] PHASE_A = 2'd0;
	localparam logic [1:0] PHASE_B = 2'd1;
	localparam logic [1:0] PHASE_C = 2'd2;

	// Bit counter value for the acknowledge clock after the eighth bit.
	localparam logic [3:0] ACK_BIT = 4'd8;

	localparam logic [15:0] HALF_RESET = 16'd500;
	localparam logic [15:0] HALF_MIN   = 16'd2;
	localparam logic [15:0] HALF_MAX   = 16'd65534;

	typedef struct packed {
		logic        clk_lvl;
		logic        dat_lvl;
		logic [15:0] hold;
		logic        last;
	} step_t;

endpackage

`default_nettype wire

FILE: rtl/tws_step_gen.sv
// ----------------------------------------------------------------------------
// tws_step_gen: pin-step decoder
// Maps the current command, bit counter and phase to one pin step.
// ----------------------------------------------------------------------------
`default_nettype none

module tws_step_gen
	import tws_pkg::*;
(
	input  wire cmd_t        cmd,
	input  wire logic [7:0]  data_byte,
	input  wire logic [3:0]  bit_idx,
	input  wire logic [1:0]  phase,
	input  wire logic        data_line,
	input  wire logic [15:0] half,
	input  wire logic [15:0] quarter,
	output step_t            step
);

	logic tx_bit;

	// MSB first
	assign tx_bit = data_byte[3'd7 - bit_idx[2:0]];

	always_comb begin
		step = '{clk_lvl: 1'b0, dat_lvl: 1'b1, hold: half, last: 1'b0};
		unique case (cmd)
			CMD_START: begin
				step.clk_lvl = 1'b1;
				step.dat_lvl = (phase == PHASE_A);
				step.last    = (phase != PHASE_A);
			end
			CMD_STOP: begin
				step.clk_lvl = 1'b0;
				step.dat_lvl = (phase != PHASE_A);
				step.last    = (phase != PHASE_A);
			end
			CMD_WRITE: begin
				if (bit_idx == ACK_BIT) begin
					// ack clock, data released, not sampled
					step.dat_lvl = 1'b1;
					step.clk_lvl = (phase != PHASE_A);
					step.last    = (phase != PHASE_A);
				end else begin
					unique case (phase)
						PHASE_A: begin
							step.clk_lvl = 1'b0;
							step.dat_lvl = data_line;
							step.hold    = quarter;
						end
						PHASE_B: begin
							step.clk_lvl = 1'b0;
							step.dat_lvl = tx_bit;
							step.hold    = quarter;
						end
						default: begin
							step.clk_lvl = 1'b1;
							step.dat_lvl = tx_bit;
						end
					endcase
				end
			end
			default: begin
				step.last = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/two_wire_write_sequencer.sv
// ----------------------------------------------------------------------------
// two_wire_write_sequencer: write-only two-wire bus master step sequencer
// Turns start / write-byte / stop commands into runs of pin-level steps.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Bits                 Contents
// s_axis    in   tdata[7:0]           data_byte
//                tuser[1:0]           command (0 start, 1 write, 2 stop)
// m_axis    out  tdata[0]             clock_level
//                tdata[1]             data_level
//                tdata[17:2]          hold_us (tdata[23:18] zero)
//                tlast                last_step
// cfg       in   cfg_wdata[15:0]      half_bit_us, written when cfg_we high
//
// Cycles: one output word per cycle while m_axis_tready is high. Start and
// stop give 2 words, a byte write 26 words; the work register issues one
// step per cycle unless the output register is stalled.
// The next command is accepted in the cycle its predecessor's last step moves
// to the output register, so commands run back to back with no gap.
// Command code 3 is accepted and produces no words.
// Reset: arst_n clears the control state and sets half_bit_us to 500.
// Stalls: a low m_axis_tready holds a waiting output word and freezes the
// work register; the input stalls until the work register's last step loads.
// ----------------------------------------------------------------------------
`default_nettype none

module two_wire_write_sequencer
	import tws_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// config
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,      // half_bit_us
	// command stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  wire logic [1:0]  s_axis_tuser,   // [1:0] command
	// pin-step stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,   // [0] clock_level, [1] data_level,
	                                         // [17:2] hold_us, rest zero
	output logic             m_axis_tlast    // last_step
);

	// half-bit time, clamped on write
	logic [15:0] half_q;
	logic [15:0] quarter;

	// work register: command being expanded
	logic        work_vld_s1;
	cmd_t        cmd_s1;
	logic [7:0]  byte_s1;
	logic [3:0]  bit_s1;
	logic [1:0]  phase_s1;

	// data line level left by the last issued step
	logic        data_line_q;

	// output register
	logic        out_vld_q;
	step_t       out_q;

	step_t       step;
	logic        load;
	logic        accept;
	cmd_t        in_cmd;

	assign quarter = {1'b0, half_q[15:1]};
	assign in_cmd  = cmd_t'(s_axis_tuser);

	tws_step_gen u_step (
		.cmd       (cmd_s1),
		.data_byte (byte_s1),
		.bit_idx   (bit_s1),
		.phase     (phase_s1),
		.data_line (data_line_q),
		.half      (half_q),
		.quarter   (quarter),
		.step      (step)
	);

	// step moves to output when the output register is free or being drained
	assign load          = work_vld_s1 && (!out_vld_q || m_axis_tready);
	assign s_axis_tready = !work_vld_s1 || (load && step.last);
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HALF_RESET;
		end else if (cfg_we) begin
			if (cfg_wdata < HALF_MIN)
				half_q <= HALF_MIN;
			else if (cfg_wdata > HALF_MAX)
				half_q <= HALF_MAX;
			else
				half_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_vld_s1 <= 1'b0;
			cmd_s1      <= CMD_START;
			bit_s1      <= '0;
			phase_s1    <= PHASE_A;
		end else if (accept) begin
			// unused code 3: swallowed, nothing issued
			work_vld_s1 <= (in_cmd != CMD_NONE);
			cmd_s1      <= in_cmd;
			bit_s1      <= '0;
			phase_s1    <= PHASE_A;
		end else if (load) begin
			if (step.last) begin
				work_vld_s1 <= 1'b0;
			end else if (cmd_s1 == CMD_WRITE && bit_s1 != ACK_BIT &&
			             phase_s1 == PHASE_C) begin
				bit_s1   <= bit_s1 + 4'd1;
				phase_s1 <= PHASE_A;
			end else begin
				phase_s1 <= phase_s1 + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			byte_s1 <= s_axis_tdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_line_q <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			if (load)
				data_line_q <= step.dat_lvl;
			if (load)
				out_vld_q <= 1'b1;
			else if (m_axis_tready)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			out_q <= step;
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {6'd0, out_q.hold, out_q.dat_lvl, out_q.clk_lvl};
	assign m_axis_tlast  = out_q.last;

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------

	a_no_idle_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		work_vld_s1 |-> cmd_s1 != CMD_NONE)
		else $error("unused command code held in work register");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		work_vld_s1 |-> phase_s1 != 2'd3)
		else $error("step phase out of range");

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		work_vld_s1 |-> bit_s1 <= ACK_BIT)
		else $error("bit counter past acknowledge");

	a_half_range: assert property (@(posedge clk) disable iff (!arst_n)
		half_q >= HALF_MIN && half_q <= HALF_MAX)
		else $error("half-bit time outside clamp range");

	a_short_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(work_vld_s1 && cmd_s1 != CMD_WRITE) |-> phase_s1 == PHASE_A || phase_s1 == PHASE_B)
		else $error("start or stop ran past two steps");

endmodule

`default_nettype wire

FILE: tb/sv/tws_step_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tws_step_checker: pin-step predictor and scoreboard
// Watches the config port and both streams, predicts the pin steps that each
// accepted command should produce and compares them with the words that leave
// the block, in order.
// ----------------------------------------------------------------------------

module tws_step_checker
	import tws_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  wire logic [1:0]  s_axis_tuser,   // [1:0] command
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [23:0] m_axis_tdata,   // [0] clock, [1] data, [17:2] hold
	input  wire logic        m_axis_tlast,   // last_step
	output int               fail_count,
	output int               pending_steps,
	output int               steps_checked
);

	step_t       step_q[$];
	logic [15:0] half_reg = HALF_RESET;
	logic        dat_line = 1'b0;

	initial begin
		fail_count    = 0;
		steps_checked = 0;
		pending_steps = 0;
	end

	function automatic logic [15:0] clamp_half(input logic [15:0] h);
		if (h < HALF_MIN)
			return HALF_MIN;
		if (h > HALF_MAX)
			return HALF_MAX;
		return h;
	endfunction

	// Each queued step also moves the predicted data line level.
	task automatic add_step(input logic c, input logic d, input logic [15:0] hold,
	                        input logic last);
		step_t s;
		s.clk_lvl = c;
		s.dat_lvl = d;
		s.hold    = hold;
		s.last    = last;
		step_q.push_back(s);
		dat_line = d;
	endtask

	task automatic predict_steps(input cmd_t cmd, input logic [7:0] din);
		logic [15:0] half_us;
		logic [15:0] quarter_us;
		half_us    = clamp_half(half_reg);
		quarter_us = half_us >> 1;
		case (cmd)
			CMD_START: begin
				add_step(1'b1, 1'b1, half_us, 1'b0);
				add_step(1'b1, 1'b0, half_us, 1'b1);
			end
			CMD_STOP: begin
				add_step(1'b0, 1'b0, half_us, 1'b0);
				add_step(1'b0, 1'b1, half_us, 1'b1);
			end
			CMD_WRITE: begin
				for (int i = 7; i >= 0; i--) begin
					add_step(1'b0, dat_line, quarter_us, 1'b0);
					add_step(1'b0, din[i], quarter_us, 1'b0);
					add_step(1'b1, din[i], half_us, 1'b0);
				end
				// ack clock, data released, not sampled
				add_step(1'b0, 1'b1, half_us, 1'b0);
				add_step(1'b1, 1'b1, half_us, 1'b1);
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		step_t want;
		if (!arst_n) begin
			half_reg = HALF_RESET;
			dat_line = 1'b0;
			step_q.delete();
			pending_steps <= 0;
		end else begin
			if (cfg_we)
				half_reg = cfg_wdata;
			if (s_axis_tvalid && s_axis_tready)
				predict_steps(cmd_t'(s_axis_tuser), s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				if (step_q.size() == 0) begin
					report_mismatch($sformatf("pin-step word %h with no step outstanding",
					                          m_axis_tdata));
				end else begin
					want = step_q.pop_front();
					if (m_axis_tdata[0] !== want.clk_lvl)
						report_mismatch($sformatf("step %0d clock_level %b, expected %b",
						                          steps_checked, m_axis_tdata[0], want.clk_lvl));
					if (m_axis_tdata[1] !== want.dat_lvl)
						report_mismatch($sformatf("step %0d data_level %b, expected %b",
						                          steps_checked, m_axis_tdata[1], want.dat_lvl));
					if (m_axis_tdata[17:2] !== want.hold)
						report_mismatch($sformatf("step %0d hold_us %0d, expected %0d",
						                          steps_checked, m_axis_tdata[17:2], want.hold));
					if (m_axis_tlast !== want.last)
						report_mismatch($sformatf("step %0d last_step %b, expected %b",
						                          steps_checked, m_axis_tlast, want.last));
					if (m_axis_tdata[23:18] !== 6'd0)
						report_mismatch($sformatf("step %0d padding bits %b, expected zero",
						                          steps_checked, m_axis_tdata[23:18]));
					steps_checked++;
				end
			end
			pending_steps <= step_q.size();
		end
	end

endmodule

FILE: tb/sv/tb_two_wire_write_sequencer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_two_wire_write_sequencer: stimulus and verdict for the step sequencer
// Drives start / write / stop commands, directed first and then random bus
// transactions, across several half-bit settings and idle / stall mixes.
// A side checker predicts and compares every pin-step word.
// ----------------------------------------------------------------------------

module tb_two_wire_write_sequencer;
	import tws_pkg::*;

	localparam int N_PHASES        = 7;
	localparam int STEP_SETTLE     = 40;    // > one byte write (26 steps) plus pipeline
	localparam int HOLD_OFF_CYCLES = 400;   // long receiver back-pressure
	localparam int IDLE_LIMIT      = 3000;  // watchdog: cycles with no word moved

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        s_valid = 1'b0;
	logic [7:0]  s_data = '0;
	logic [1:0]  s_user = CMD_START;
	logic        m_ready = 1'b0;
	logic        hold_req = 1'b0;
	logic        hold_done = 1'b0;

	wire         s_ready;
	wire         m_valid;
	wire  [23:0] m_data;
	wire         m_last;

	// idle / stall odds out of 100, changed between phases
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	int fail_count;
	int pending_steps;
	int steps_checked;
	int cmd_count[4] = '{0, 0, 0, 0};
	int half_writes = 0;
	int idle_cycles = 0;

	int          idle_tab[N_PHASES]  = '{76, 0, 6, 0, 76, 0, 6};
	int          stall_tab[N_PHASES] = '{0, 76, 6, 0, 0, 76, 6};
	logic [15:0] half_tab[N_PHASES]  = '{16'd0, 16'hFFFF, 16'd1, HALF_MAX, 16'd3, 16'd0,
	                                     HALF_MIN};

	always #4 clk = ~clk;

	two_wire_write_sequencer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_ready),
		.s_axis_tdata  (s_data),
		.s_axis_tuser  (s_user),
		.m_axis_tvalid (m_valid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_data),
		.m_axis_tlast  (m_last)
	);

	tws_step_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_ready),
		.s_axis_tdata  (s_data),
		.s_axis_tuser  (s_user),
		.m_axis_tvalid (m_valid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_data),
		.m_axis_tlast  (m_last),
		.fail_count    (fail_count),
		.pending_steps (pending_steps),
		.steps_checked (steps_checked)
	);

	// Offer one command word; returns in the time step of the accepting edge
	// with tvalid still high, so the next call either replaces the word or
	// drops tvalid for a gap (one nonblocking write either way).
	task automatic push_command(input cmd_t cmd, input logic [7:0] din);
		while ($urandom_range(99) < send_idle_pct) begin
			s_valid <= 1'b0;
			s_data  <= 8'($urandom);     // garbage while idle
			@(posedge clk);
		end
		s_valid <= 1'b1;
		s_user  <= cmd;
		s_data  <= din;
		@(posedge clk);
		while (!s_ready)
			@(posedge clk);
		cmd_count[cmd]++;
	endtask

	// Drop tvalid and sit until every predicted step has left the block.
	// pending_steps is updated by nonblocking write, so the first edge lets
	// the last accepted command show up in the count.
	task automatic wait_drained();
		s_valid <= 1'b0;
		@(posedge clk);
		while (pending_steps != 0)
			@(posedge clk);
	endtask

	// Register writes only with the block idle. An unused command leaves no
	// step behind, so a fixed settle follows the drain.
	task automatic write_half(input logic [15:0] value);
		wait_drained();
		repeat (STEP_SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		half_writes++;
	endtask

	// Random traffic: mostly well-formed start / bytes / stop frames, plus
	// single noise commands (unused code included) and broken frames.
	task automatic run_traffic(input int n_items);
		int   sent;
		int   pick;
		int   n_wr;
		cmd_t cmd;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(9);
			if (pick < 7) begin
				push_command(CMD_START, 8'($urandom));
				n_wr = $urandom_range(1, 4);
				repeat (n_wr) push_command(CMD_WRITE, 8'($urandom));
				push_command(CMD_STOP, 8'($urandom));
				sent += n_wr + 2;
			end else if (pick == 7) begin
				cmd = cmd_t'($urandom_range(3));
				push_command(cmd, 8'($urandom));
				if (cmd != CMD_NONE)
					sent++;
			end else begin
				// byte with no start, then a repeated start left open
				push_command(CMD_WRITE, 8'($urandom));
				push_command(CMD_START, 8'($urandom));
				sent += 2;
			end
		end
	endtask

	// Receiver: random stalls, plus one long hold-off on request, counted here
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				m_ready  <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			m_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: any word moved on either stream restarts the count
	always @(posedge clk) begin
		if (!arst_n || (s_valid && s_ready) || (m_valid && m_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset half-bit (500), no idling.
		// Byte straight out of reset: first quarter step holds data low.
		push_command(CMD_WRITE, 8'hA5);
		push_command(CMD_START, 8'hFF);     // byte ignored on start
		push_command(CMD_WRITE, 8'h00);
		push_command(CMD_WRITE, 8'hFF);
		push_command(CMD_WRITE, 8'h80);
		push_command(CMD_WRITE, 8'h01);
		push_command(CMD_STOP, 8'h3C);      // byte ignored on stop
		push_command(CMD_NONE, 8'hFF);      // unused code, no steps
		push_command(CMD_WRITE, 8'h55);     // after stop, data line starts high
		push_command(CMD_START, 8'h00);
		push_command(CMD_WRITE, 8'hAA);
		push_command(CMD_NONE, 8'h00);
		push_command(CMD_STOP, 8'h00);
		push_command(CMD_STOP, 8'hC3);      // back-to-back stops
		push_command(CMD_START, 8'h5A);
		push_command(CMD_START, 8'h7E);     // repeated start
		push_command(CMD_WRITE, 8'h7E);
		push_command(CMD_STOP, 8'h81);

		// Random phases: 0 and 1 clamp to 2, all-ones clamps to 65534,
		// 3 gives a quarter of 1.
		for (int p = 0; p < N_PHASES; p++) begin
			write_half((p == 5) ? 16'($urandom_range(65535)) : half_tab[p]);
			send_idle_pct  <= idle_tab[p];
			recv_stall_pct <= stall_tab[p];
			if (p == 3)
				hold_req <= 1'b1;           // sender keeps offering, block backs up
			if (p == 4) begin
				run_traffic(10);
				wait_drained();             // sender pause until all steps are out
				run_traffic(9);
			end else begin
				run_traffic(19);
			end
		end

		wait_drained();
		repeat (STEP_SETTLE) @(posedge clk);

		$display("Ran %0d start, %0d write, %0d stop and %0d unused commands,",
		         cmd_count[CMD_START], cmd_count[CMD_WRITE], cmd_count[CMD_STOP],
		         cmd_count[CMD_NONE]);
		$display("checking %0d pin steps over %0d half-bit settings plus reset default.",
		         steps_checked, half_writes);
		if (fail_count == 0 && pending_steps == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/tws_pkg.sv
rtl/tws_step_gen.sv
rtl/two_wire_write_sequencer.sv
tb/sv/tws_step_checker.sv
tb/sv/tb_two_wire_write_sequencer.sv
